// ===== src/ias_pkg.sv =====
package ias_pkg;

    localparam int MaxLevels  = 3;
    localparam int FrameBytes = 9;
    localparam int UidBytes   = 10;

    // action codes on the input tuser
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    // receive status codes
    localparam logic [1:0] RX_OK      = 2'd0;
    localparam logic [1:0] RX_COLL    = 2'd1;
    localparam logic [1:0] RX_LINK    = 2'd2;
    localparam logic [1:0] RX_TIMEOUT = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_COLL     = 3'd1;
    localparam logic [2:0] ST_INTERNAL = 3'd2;
    localparam logic [2:0] ST_BAD_SAK  = 3'd3;
    localparam logic [2:0] ST_CRC      = 3'd4;
    localparam logic [2:0] ST_LINK     = 3'd5;
    localparam logic [2:0] ST_TIMEOUT  = 3'd6;

    localparam logic [7:0]  SEL_CL1     = 8'h93;
    localparam logic [7:0]  NVB_SELECT  = 8'h70;
    localparam logic [7:0]  CASCADE_TAG = 8'h88;
    localparam logic [15:0] CRC_PRESET  = 16'h6363;
    localparam logic [15:0] CRC_POLY    = 16'h8408;

    typedef enum logic [1:0] {
        OP_START,
        OP_BYTE,
        OP_END
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ANTICOLL,
        PH_SELECT
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BEGIN,
        S_FRAME,
        S_CRC,
        S_EMIT,
        S_FIN,
        S_RES,
        S_FAIL
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic [1:0] rx_status;
        logic       coll_pos_valid;
        logic [4:0] coll_pos;
        logic [2:0] rx_last_bits;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/iso14443a_anticollision_select_core.sv =====
// path: an accepted start reaches the first frame byte at the output, and an accepted
// end reaches the next anticollision or select frame, through the front register, a
// queue slot and the sequencer setup, with the crc_a steps added for a select frame
// throughput: one byte transaction per cycle while the sequencer is idle; frames and results leave one byte
// per cycle while the output is taken
// reset: synchronous active-low i_rst_n clears queue, sequencer and phase, and sets level to 1
module iso14443a_anticollision_select_core
    import ias_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // rx_byte, rx_status, coll_pos_valid, coll_pos, rx_last_bits
    input  logic [1:0]  i_s_axis_tuser,  // action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // out_byte, tx_last_bits, rx_align, status, uid_size, sak
    output logic        o_m_axis_tuser,  // kind
    output logic        o_m_axis_tlast
);

    logic q_full, q_empty, push, pop;
    t_cmd f_cmd, q_cmd;

    ias_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (f_cmd)
    );

    ias_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    ias_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// ===== src/ias_front.sv =====
module ias_front
    import ias_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // rx_byte, rx_status, coll_pos_valid, coll_pos, rx_last_bits
    input  logic [1:0]  i_s_axis_tuser,  // action
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic accept, keep;
    t_op  op_dec;

    always_comb begin
        keep   = 1'b1;
        op_dec = OP_START;
        case (i_s_axis_tuser)
            ACT_START: op_dec = OP_START;
            ACT_BYTE:  op_dec = OP_BYTE;
            ACT_END:   op_dec = OP_END;
            default:   keep = 1'b0;
        endcase
    end

    assign o_s_axis_tready = !r_valid || !i_q_full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = r_valid && !i_q_full;
    assign o_cmd           = r_cmd;

    always_comb begin
        n_valid = o_push ? 1'b0 : r_valid;
        n_cmd   = r_cmd;
        if (accept && keep) begin
            n_valid              = 1'b1;
            n_cmd.op             = op_dec;
            n_cmd.rx_byte        = i_s_axis_tdata[7:0];
            n_cmd.rx_status      = i_s_axis_tdata[9:8];
            n_cmd.coll_pos_valid = i_s_axis_tdata[10];
            n_cmd.coll_pos       = i_s_axis_tdata[15:11];
            n_cmd.rx_last_bits   = i_s_axis_tdata[18:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

// ===== src/ias_queue.sv =====
module ias_queue
    import ias_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== src/ias_back.sv =====
module ias_back
    import ias_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [1:0]  r_level, n_level;
    logic [5:0]  r_kbc, n_kbc;
    logic [3:0]  r_rxi, n_rxi;
    logic [7:0]  r_fs [FrameBytes];
    logic [7:0]  n_fs [FrameBytes];
    logic [7:0]  r_uid [UidBytes];
    logic [7:0]  n_uid [UidBytes];
    logic [3:0]  r_cnt, n_cnt;
    logic [3:0]  r_used, n_used;
    logic [2:0]  r_txl, n_txl;
    logic [15:0] r_crc, n_crc;
    logic [2:0]  r_lbits, n_lbits;
    logic [2:0]  r_err, n_err;

    logic        r_ov;
    logic        r_o_kind, r_o_last;
    logic [7:0]  r_o_byte, r_o_sak;
    logic [2:0]  r_o_txl, r_o_rxa, r_o_st;
    logic [3:0]  r_o_size;
    logic        out_free, out_load;
    logic        o_kind, o_last;
    logic [7:0]  o_byte, o_sak;
    logic [2:0]  o_txl, o_rxa, o_st;
    logic [3:0]  o_size;

    logic [3:0]  start, room, idx, rd_addr, nres, fidx;
    logic [5:0]  pos;
    logic [7:0]  mask, fs_rd, rx_v, m_part, xor_bcc;
    logic [15:0] crc_n, crc_s;
    logic        cmd_ok;

    assign out_free = !r_ov || i_m_axis_tready;
    assign cmd_ok   = (r_state == S_IDLE) && !i_q_empty;
    assign o_pop    = cmd_ok;

    assign start  = (r_phase == PH_SELECT) ? 4'd6 : 4'd2 + {1'b0, r_kbc[5:3]};
    assign room   = 4'(FrameBytes) - start;
    assign pos    = (i_cmd.coll_pos == 5'd0) ? 6'd32 : {1'b0, i_cmd.coll_pos};
    assign idx    = 4'd1 + {1'b0, pos[5:3]} + {3'b000, pos[2:0] != 3'd0};
    assign mask   = 8'd1 << 3'(pos - 6'd1);
    assign nres   = {1'b0, r_level, 1'b0} + {2'b00, r_level} + 4'd1;
    assign fidx   = 4'd2 + {1'b0, r_kbc[5:3]};
    assign m_part = 8'((9'd1 << r_kbc[2:0]) - 9'd1);
    assign xor_bcc = r_fs[2] ^ r_fs[3] ^ r_fs[4] ^ r_fs[5];
    assign crc_s  = crc_byte(CRC_PRESET, r_fs[6]);

    // single addressed read port on the frame store; fixed bytes are read directly
    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = (i_cmd.op == OP_END) ? idx : start + r_rxi;
            default: rd_addr = r_cnt;
        endcase
    end
    assign fs_rd = (rd_addr < 4'(FrameBytes)) ? r_fs[rd_addr] : 8'h00;
    assign crc_n = crc_byte(r_crc, fs_rd);

    // partial first byte keeps the known low bits
    assign rx_v = (r_phase == PH_ANTICOLL && r_rxi == 4'd0 && r_kbc[2:0] != 3'd0)
                ? ((fs_rd & m_part) | (i_cmd.rx_byte & ~m_part)) : i_cmd.rx_byte;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cmd_ok) begin
                    case (i_cmd.op)
                        OP_START: n_state = S_BEGIN;
                        OP_END: begin
                            if (r_phase != PH_IDLE) begin
                                if (i_cmd.rx_status == RX_TIMEOUT || i_cmd.rx_status == RX_LINK
                                    || r_rxi > room) begin
                                    n_state = S_FAIL;
                                end else if (i_cmd.rx_status == RX_COLL) begin
                                    n_state = (!i_cmd.coll_pos_valid || pos <= r_kbc)
                                            ? S_FAIL : S_FRAME;
                                end else begin
                                    n_state = (r_phase == PH_ANTICOLL) ? S_FRAME : S_FIN;
                                end
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_BEGIN: n_state = S_FRAME;
            S_FRAME: n_state = r_kbc[5] ? S_CRC : S_EMIT;
            S_CRC:   n_state = (r_cnt == 4'd6) ? S_EMIT : S_CRC;
            S_EMIT: begin
                if (out_free && r_cnt == r_used - 4'd1) begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (r_rxi != 4'd3 || r_lbits != 3'd0 || r_fs[7] != crc_s[7:0]
                    || r_fs[8] != crc_s[15:8]) begin
                    n_state = S_FAIL;
                end else if (r_fs[6][2]) begin
                    n_state = (r_level >= 2'(MaxLevels)) ? S_FAIL : S_BEGIN;
                end else begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (out_free && r_cnt == nres - 4'd1) begin
                    n_state = S_IDLE;
                end
            end
            S_FAIL:  n_state = out_free ? S_IDLE : S_FAIL;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_phase = r_phase;
        n_level = r_level;
        n_kbc   = r_kbc;
        n_rxi   = r_rxi;
        n_fs    = r_fs;
        n_uid   = r_uid;
        n_cnt   = r_cnt;
        n_used  = r_used;
        n_txl   = r_txl;
        n_crc   = r_crc;
        n_lbits = r_lbits;
        n_err   = r_err;
        case (r_state)
            S_IDLE: begin
                n_cnt = 4'd0;
                if (cmd_ok) begin
                    case (i_cmd.op)
                        OP_START: n_level = 2'd1;
                        OP_BYTE: begin
                            if (r_phase != PH_IDLE) begin
                                if (r_rxi < room) begin
                                    n_fs[start + r_rxi] = rx_v;
                                end
                                if (r_rxi != 4'd15) begin
                                    n_rxi = r_rxi + 4'd1;
                                end
                            end
                        end
                        OP_END: begin
                            n_lbits = i_cmd.rx_last_bits;
                            if (r_phase != PH_IDLE) begin
                                n_phase = PH_IDLE;
                                if (i_cmd.rx_status == RX_TIMEOUT) begin
                                    n_err = ST_TIMEOUT;
                                end else if (i_cmd.rx_status == RX_LINK) begin
                                    n_err = ST_LINK;
                                end else if (r_rxi > room) begin
                                    n_err = ST_INTERNAL;
                                end else if (i_cmd.rx_status == RX_COLL) begin
                                    if (!i_cmd.coll_pos_valid) begin
                                        n_err = ST_COLL;
                                    end else if (pos <= r_kbc) begin
                                        n_err = ST_INTERNAL;
                                    end else begin
                                        n_phase   = r_phase;
                                        n_kbc     = pos;
                                        n_fs[idx] = fs_rd | mask;
                                    end
                                end else begin
                                    n_phase = r_phase;
                                    if (r_phase == PH_ANTICOLL) begin
                                        n_kbc = 6'd32;
                                    end
                                end
                            end
                        end
                        default: n_cnt = 4'd0;
                    endcase
                end
            end
            S_BEGIN: begin
                n_fs[0] = SEL_CL1 + {5'd0, r_level - 2'd1, 1'b0};
                for (int i = 1; i < FrameBytes; i++) begin
                    n_fs[i] = 8'h00;
                end
                n_kbc = 6'd0;
            end
            S_FRAME: begin
                n_rxi = 4'd0;
                n_cnt = 4'd0;
                if (r_kbc[5]) begin
                    n_fs[1] = NVB_SELECT;
                    n_fs[6] = xor_bcc;
                    n_crc   = CRC_PRESET;
                    n_phase = PH_SELECT;
                end else begin
                    n_fs[1] = {fidx, 1'b0, r_kbc[2:0]};
                    n_used  = fidx + {3'b000, r_kbc[2:0] != 3'd0};
                    n_txl   = r_kbc[2:0];
                    n_phase = PH_ANTICOLL;
                end
            end
            S_CRC: begin
                n_crc = crc_n;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd6) begin
                    n_fs[7] = crc_n[7:0];
                    n_fs[8] = crc_n[15:8];
                    n_used  = 4'(FrameBytes);
                    n_txl   = 3'd0;
                    n_cnt   = 4'd0;
                end
            end
            S_EMIT, S_RES: begin
                if (out_free) begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_FIN: begin
                for (int i = 0; i < 4; i++) begin
                    if (r_fs[2] == CASCADE_TAG) begin
                        if (i < 3) begin
                            case (r_level)
                                2'd1:    n_uid[i]     = r_fs[3 + i];
                                2'd2:    n_uid[3 + i] = r_fs[3 + i];
                                default: n_uid[6 + i] = r_fs[3 + i];
                            endcase
                        end
                    end else begin
                        case (r_level)
                            2'd1:    n_uid[i]     = r_fs[2 + i];
                            2'd2:    n_uid[3 + i] = r_fs[2 + i];
                            default: n_uid[6 + i] = r_fs[2 + i];
                        endcase
                    end
                end
                n_cnt   = 4'd0;
                n_phase = PH_IDLE;
                if (r_rxi != 4'd3 || r_lbits != 3'd0) begin
                    n_err = ST_BAD_SAK;
                end else if (r_fs[7] != crc_s[7:0] || r_fs[8] != crc_s[15:8]) begin
                    n_err = ST_CRC;
                end else if (r_fs[6][2]) begin
                    if (r_level >= 2'(MaxLevels)) begin
                        n_err = ST_INTERNAL;
                    end else begin
                        n_phase = r_phase;
                        n_level = r_level + 2'd1;
                    end
                end
            end
            default: n_cnt = r_cnt;
        endcase
    end

    // outputs
    always_comb begin
        out_load = 1'b0;
        o_kind   = 1'b0;
        o_byte   = 8'h00;
        o_txl    = 3'd0;
        o_rxa    = 3'd0;
        o_st     = ST_OK;
        o_size   = 4'd0;
        o_sak    = 8'h00;
        o_last   = 1'b0;
        case (r_state)
            S_EMIT: begin
                out_load = out_free;
                o_byte   = fs_rd;
                o_txl    = r_txl;
                o_rxa    = r_txl;
                o_last   = (r_cnt == r_used - 4'd1);
            end
            S_RES: begin
                out_load = out_free;
                o_kind   = 1'b1;
                o_byte   = (r_cnt < 4'(UidBytes)) ? r_uid[r_cnt] : 8'h00;
                o_size   = nres;
                o_sak    = r_fs[6];
                o_last   = (r_cnt == nres - 4'd1);
            end
            S_FAIL: begin
                out_load = out_free;
                o_kind   = 1'b1;
                o_st     = r_err;
                o_last   = 1'b1;
            end
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_level <= 2'd1;
            r_kbc   <= 6'd0;
            r_rxi   <= 4'd0;
            r_crc   <= CRC_PRESET;
            r_cnt   <= 4'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_level <= n_level;
            r_kbc   <= n_kbc;
            r_rxi   <= n_rxi;
            r_crc   <= n_crc;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
        r_fs    <= n_fs;
        r_uid   <= n_uid;
        r_used  <= n_used;
        r_txl   <= n_txl;
        r_lbits <= n_lbits;
        r_err   <= n_err;
        if (out_load) begin
            r_o_kind <= o_kind;
            r_o_byte <= o_byte;
            r_o_txl  <= o_txl;
            r_o_rxa  <= o_rxa;
            r_o_st   <= o_st;
            r_o_size <= o_size;
            r_o_sak  <= o_sak;
            r_o_last <= o_last;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = {3'b000, r_o_sak, r_o_size, r_o_st, r_o_rxa, r_o_txl, r_o_byte};

`ifndef ASSERT_OFF
    a_kbc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kbc <= 6'd32) else $error("known bit count beyond 32");
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level != 2'd0) else $error("cascade level zero");
    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_cnt < r_used) else $error("frame emit past end");
    a_crc_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CRC |-> r_cnt < 4'd7) else $error("crc pointer past bcc");
    a_fail_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FAIL |-> r_phase == PH_IDLE) else $error("fail while phase active");
`endif

endmodule
